[rtl/sld_pkg.sv]
//------------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sound level high mode detector.
//------------------------------------------------------------------------------
package sld_pkg;

  localparam int GAIN_SHIFT_DEF       = 0;
  localparam int SAMPLE_BITS_DEF      = 10;
  localparam int MAX_LOG2_SAMPLES_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOG2_SAMPLES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE_GAP_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE_LIMIT  = 3'd4;

  localparam logic [1:0] TREND_SAME = 2'd0;
  localparam logic [1:0] TREND_UP   = 2'd1;
  localparam logic [1:0] TREND_DOWN = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [9:0] sample;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [13:0] raw_level;
    logic [13:0] gated_level;
    logic [13:0] block_mean;
    logic [13:0] block_peak;
    logic [13:0] song_average;
    logic [1:0]  trend;
    logic        high_mode;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  log2_samples;
    logic [12:0] noise_level;
    logic [11:0] avg_window;
    logic [15:0] strike_gap_ms;
    logic [7:0]  strike_limit;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic tick;       // advance millisecond counter
    logic acc;        // accumulate the held sample
    logic blk_start;  // latch block stats, start square root
    logic sqrt_step;  // one root iteration
    logic div_start;  // gate level, update song sum, start divide
    logic div_step;   // one divide iteration
    logic finish;     // average restart, strikes, build result
  } sld_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic blk_end;    // accumulated sample closed the block
    logic sqrt_done;
    logic raw_zero;
    logic div_done;
  } sld_stat_t;

endpackage

[rtl/sld_datapath.sv]
//------------------------------------------------------------------------------
// sld_datapath
// Accumulators, iterative square root, iterative divider and strike logic.
//------------------------------------------------------------------------------
module sld_datapath #(
  parameter int GAIN_SHIFT       = sld_pkg::GAIN_SHIFT_DEF,
  parameter int MAX_LOG2_SAMPLES = sld_pkg::MAX_LOG2_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sld_pkg::cfg_t      cfg,
  input  sld_pkg::in_item_t  item,
  input  sld_pkg::sld_cmd_t  cmd,
  output sld_pkg::sld_stat_t stat,
  output sld_pkg::out_item_t result
);

  localparam int SAMPLE_BITS = sld_pkg::SAMPLE_BITS_DEF;
  localparam int AMP_W  = SAMPLE_BITS + GAIN_SHIFT;
  localparam int CNT_W  = MAX_LOG2_SAMPLES + 1;
  localparam int SUM_W  = AMP_W + MAX_LOG2_SAMPLES;
  localparam int SQ_W   = 2 * AMP_W + MAX_LOG2_SAMPLES;
  localparam int SQ_IT  = (SQ_W + 1) / 2;
  localparam int MS_W   = 2 * SQ_IT;
  localparam int ROOT_W = SQ_IT;
  localparam int SIT_W  = $clog2(SQ_IT + 1);
  localparam int LVL_W  = (SQ_IT > 14) ? SQ_IT : 14;
  localparam int SC_W   = 13;
  localparam int SS_W   = LVL_W + SC_W;
  localparam int DIT_W  = $clog2(SS_W + 1);
  localparam int LHS_W  = SS_W + 4;
  localparam logic [SAMPLE_BITS-1:0] MID = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  logic [31:0]            time_ms, last_strike_ms;
  logic [7:0]             strike_count;
  logic                   loud_mode;
  logic [CNT_W-1:0]       samples_seen;
  logic [SUM_W-1:0]       amp_sum;
  logic [SQ_W-1:0]        amp_square_sum;
  logic [AMP_W-1:0]       amp_peak;
  logic [SS_W-1:0]        song_sum;
  logic [SC_W-1:0]        song_count;
  logic [LVL_W-1:0]       song_avg_floor;

  // accumulate
  logic [SAMPLE_BITS-1:0] s;
  logic [AMP_W-1:0]       amp;
  logic [3:0]             l;
  logic [CNT_W-1:0]       seen_next;
  always_comb begin
    s = item.sample[SAMPLE_BITS-1:0];
    amp = AMP_W'(((s >= MID) ? (s - MID) : (MID - s))) << GAIN_SHIFT;
    l = (cfg.log2_samples > 4'(MAX_LOG2_SAMPLES)) ? 4'(MAX_LOG2_SAMPLES)
                                                    : cfg.log2_samples;
    seen_next = samples_seen + CNT_W'(1);
  end

  logic [2*AMP_W-1:0] amp_sq;
  assign amp_sq = amp * amp;

  // block totals including the sample being accumulated
  logic [SUM_W-1:0] sum_next;
  logic [SQ_W-1:0]  sq_next;
  logic [AMP_W-1:0] peak_next;
  always_comb begin
    sum_next  = amp_sum + SUM_W'(amp);
    sq_next   = amp_square_sum + SQ_W'(amp_sq);
    peak_next = (amp > amp_peak) ? amp : amp_peak;
  end

  // square root state
  logic [MS_W-1:0]   rem;
  logic [ROOT_W:0]   root;
  logic [SIT_W-1:0]  sq_it;
  logic [13:0]       mean_r, peak_r;
  logic [LVL_W-1:0]  raw_r;
  logic [MS_W+1:0]   trial;
  logic [1:0]        pair;
  always_comb begin
    pair  = 2'(rem >> (2 * (SQ_IT - 1)));
    trial = {MS_W'(root), 2'b01};
  end

  // divider state: song_sum / song_count
  logic [SS_W-1:0]   dq;
  logic [SC_W:0]     drem;
  logic [SC_W-1:0]   ddiv;
  logic [DIT_W-1:0]  d_it;
  logic [LVL_W-1:0]  gated_r, gated_calc, avg_q;
  logic [SS_W-1:0]   loud_sum;
  logic [SC_W-1:0]   loud_cnt;
  logic [SC_W:0]     drem_sh;
  assign drem_sh = {drem[SC_W-1:0], dq[SS_W-1]};

  always_comb begin
    gated_calc = (raw_r > LVL_W'(cfg.noise_level)) ?
                 raw_r - LVL_W'(cfg.noise_level) : '0;
    avg_q      = LVL_W'(dq);
  end

  // sqrt remainder tracked separately
  logic [MS_W+1:0] srem;

  // strike logic (combinational on registered values at finish)
  logic [31:0] elapsed, ls_next;
  logic        late, loud, lm_next;
  logic [7:0]  sc_next;
  logic [LHS_W-1:0] lhs, rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms <= '0; last_strike_ms <= '0; strike_count <= '0; loud_mode <= 1'b0;
      samples_seen <= '0; amp_sum <= '0; amp_square_sum <= '0; amp_peak <= '0;
      song_sum <= '0; song_count <= '0; song_avg_floor <= '0;
      sq_it <= '0; d_it <= '0;
    end else begin
      if (cmd.tick) time_ms <= time_ms + 32'd1;
      if (cmd.acc) begin
        if (cmd.blk_start) begin
          samples_seen <= '0; amp_sum <= '0; amp_square_sum <= '0; amp_peak <= '0;
        end else begin
          samples_seen   <= seen_next;
          amp_sum        <= sum_next;
          amp_square_sum <= sq_next;
          amp_peak       <= peak_next;
        end
      end
      if (cmd.blk_start) begin
        mean_r <= 14'(sum_next >> l);
        peak_r <= 14'(peak_next);
        rem    <= MS_W'(sq_next >> l);
        srem   <= '0;
        root   <= '0;
        sq_it  <= '0;
      end
      if (cmd.sqrt_step) begin
        // bring down two bits, try subtracting 4r+1
        if ({srem[MS_W-1:0], pair} >= trial) begin
          srem <= {srem[MS_W-1:0], pair} - trial;
          root <= {root[ROOT_W-1:0], 1'b1};
        end else begin
          srem <= {srem[MS_W-1:0], pair};
          root <= {root[ROOT_W-1:0], 1'b0};
        end
        rem   <= rem << 2;
        sq_it <= sq_it + SIT_W'(1);
      end
      if (cmd.div_start) begin
        gated_r    <= gated_calc;
        song_sum   <= song_sum + SS_W'(gated_calc);
        song_count <= song_count + SC_W'(1);
        dq   <= song_sum + SS_W'(gated_calc);
        ddiv <= song_count + SC_W'(1);
        drem <= '0;
        d_it <= '0;
      end
      if (cmd.div_step) begin
        if (drem_sh >= {1'b0, ddiv}) begin
          drem <= drem_sh - {1'b0, ddiv};
          dq   <= {dq[SS_W-2:0], 1'b1};
        end else begin
          drem <= drem_sh;
          dq   <= {dq[SS_W-2:0], 1'b0};
        end
        d_it <= d_it + DIT_W'(1);
      end
      if (cmd.finish) begin
        result.accepted    <= ~stat.raw_zero;
        result.raw_level   <= 14'(raw_r);
        result.block_mean  <= mean_r;
        result.block_peak  <= peak_r;
        result.gated_level <= stat.raw_zero ? 14'd0 : 14'(gated_r);
        if (stat.raw_zero) begin
          result.song_average <= 14'(song_avg_floor);
          result.trend        <= sld_pkg::TREND_SAME;
          result.high_mode    <= loud_mode;
        end else begin
          song_avg_floor <= avg_q;
          result.song_average <= 14'(avg_q);
          result.trend <= (avg_q == song_avg_floor) ? sld_pkg::TREND_SAME :
                          (avg_q > song_avg_floor) ? sld_pkg::TREND_UP :
                                                     sld_pkg::TREND_DOWN;
          if (song_count > SC_W'(cfg.avg_window)) begin
            song_sum   <= SS_W'(avg_q);
            song_count <= SC_W'(1);
          end
          strike_count <= sc_next;
          loud_mode    <= lm_next;
          last_strike_ms <= ls_next;
          result.high_mode <= lm_next;
        end
      end
    end
  end

  always_comb raw_r = LVL_W'(root);

  assign loud_sum = song_sum;
  assign loud_cnt = song_count;
  always_comb begin
    elapsed = time_ms - last_strike_ms;
    late    = elapsed > 32'(cfg.strike_gap_ms);
    lhs     = LHS_W'(gated_r) * LHS_W'(loud_cnt) * LHS_W'(10);
    rhs     = LHS_W'(loud_sum) * LHS_W'(11);
    loud    = lhs > rhs;
    sc_next = strike_count;
    lm_next = loud_mode;
    ls_next = last_strike_ms;
    if (loud) begin
      if (strike_count != 8'd0) begin
        if (late) begin
          sc_next = 8'd0; lm_next = 1'b0;
        end else begin
          ls_next = time_ms;
          if (strike_count != 8'd255) sc_next = strike_count + 8'd1;
        end
      end else begin
        sc_next = 8'd1; ls_next = time_ms;
      end
    end
    if (sc_next != 8'd0 && late) begin
      sc_next = 8'd0; lm_next = 1'b0;
    end else if (sc_next > cfg.strike_limit) begin
      lm_next = 1'b1;
    end
  end

  always_comb begin
    stat.blk_end   = cmd.acc && (seen_next >= (CNT_W'(1) << l));
    stat.sqrt_done = (sq_it == SIT_W'(SQ_IT));
    stat.raw_zero  = (root == '0);
    stat.div_done  = (d_it == DIT_W'(SS_W));
  end

endmodule

[rtl/sld_ctrl.sv]
//------------------------------------------------------------------------------
// sld_ctrl
// Sequencer: accept, accumulate, square root, divide, result handoff.
//------------------------------------------------------------------------------
module sld_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               in_tick,
  input  logic               out_busy,
  input  sld_pkg::sld_stat_t stat,
  output sld_pkg::sld_cmd_t  cmd,
  output logic               idle,
  output logic               load_out
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,
    S_SQRT = 6'b000100,
    S_DIVS = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    cmd = '0;
    load_out = 1'b0;
    state_next = state;
    idle = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tick) cmd.tick = 1'b1;
          else         state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_next = S_IDLE;
        if (stat.blk_end) begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (!stat.sqrt_done) begin
          cmd.sqrt_step = 1'b1;
        end else if (stat.raw_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIVS: state_next = S_DIV;
      S_DIV: begin
        if (!stat.div_done) cmd.div_step = 1'b1;
        else                state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // block start happens on the accumulate cycle that closes the block
    cmd.blk_start = cmd.acc && stat.blk_end;
  end

endmodule

[rtl/sound_level_high_mode_detector_unit.sv]
//------------------------------------------------------------------------------
// sound_level_high_mode_detector_unit
// Sound level meter with loud high mode detection.
//------------------------------------------------------------------------------
// Sample: accepted while idle, then accumulated in the datapath; a tick is taken
// while idle. Block end: bit-pair square root, restoring divide for the song
// average (skipped for a discarded block), then the result is registered and
// out_valid rises; input waits meanwhile, and longer while an older result is
// stalled.
// Synchronous reset clears all statistics and loads register defaults.
module sound_level_high_mode_detector_unit #(
  parameter int GAIN_SHIFT       = sld_pkg::GAIN_SHIFT_DEF,
  parameter int MAX_LOG2_SAMPLES = sld_pkg::MAX_LOG2_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sld_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sld_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sld_pkg::out_item_t              out_item
);

  sld_pkg::cfg_t      cfg;
  sld_pkg::sld_cmd_t  cmd;
  sld_pkg::sld_stat_t stat;
  sld_pkg::out_item_t result;
  sld_pkg::in_item_t  held;
  logic idle, load_out, in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log2_samples  <= 4'd6;
      cfg.noise_level   <= 13'd0;
      cfg.avg_window    <= 12'd600;
      cfg.strike_gap_ms <= 16'd200;
      cfg.strike_limit  <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sld_pkg::REG_LOG2_SAMPLES:  cfg.log2_samples  <= cfg_data[3:0];
        sld_pkg::REG_NOISE_LEVEL:   cfg.noise_level   <= cfg_data[12:0];
        sld_pkg::REG_AVG_WINDOW:    cfg.avg_window    <= cfg_data[11:0];
        sld_pkg::REG_STRIKE_GAP_MS: cfg.strike_gap_ms <= cfg_data;
        sld_pkg::REG_STRIKE_LIMIT:  cfg.strike_limit  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = idle;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) held <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  assign out_item = result;

  sld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_tick  (in_item.cmd),
    .out_busy (out_valid && !out_ready),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .load_out (load_out)
  );

  sld_datapath #(
    .GAIN_SHIFT       (GAIN_SHIFT),
    .MAX_LOG2_SAMPLES (MAX_LOG2_SAMPLES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (held),
    .cmd    (cmd),
    .stat   (stat),
    .result (result)
  );

endmodule

[rtl/sld_checker.sv]
//------------------------------------------------------------------------------
// sld_checker
// Port-level checks for the sound level detector.
//------------------------------------------------------------------------------
module sld_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sld_pkg::out_item_t out_item
);

  // an offered input stays offered until its transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_ready) |=> in_valid)
    else $error("input withdrawn before transfer");

  // a result stays offered until its transfer
  a_out_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_item))
    else $error("stalled result changed");

  a_discard_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.accepted) |-> (out_item.gated_level == 14'd0 &&
     out_item.raw_level == 14'd0))
    else $error("discarded block with nonzero level");

  a_trend_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.trend != 2'd3))
    else $error("bad trend");

endmodule

bind sound_level_high_mode_detector_unit sld_checker u_sld_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
